/* sv/amar_pkg.sv */
// ----------------------------------------------------------------------------
// amar_pkg
// shared constants and decimal digit helpers for the millivolt ascii reporter
// ----------------------------------------------------------------------------
`default_nettype none

package amar_pkg;

  // millivolt value width, enough for 1023 * 5
  localparam int MV_W    = 13;
  localparam int Q_DEPTH = 2;
  localparam int MV_PER_COUNT = 5;

  localparam logic [7:0] ASCII_ZERO      = 8'd48;
  localparam logic [7:0] ASCII_POINT     = 8'd46;
  localparam logic [7:0] ASCII_BACKSPACE = 8'd8;

  // byte positions within one report
  localparam int POS_THOUS = 0;
  localparam int POS_POINT = 1;
  localparam int POS_HUND  = 2;
  localparam int POS_TENS  = 3;
  localparam int POS_UNITS = 4;

  localparam int DIGIT_BYTES = 5;

  function automatic logic [3:0] dec_digit(input logic [MV_W-1:0] v, input int w);
    logic [3:0] d;
    d = '0;
    for (int k = 1; k < 10; k++) begin
      if (int'(v) >= k * w) begin
        d = 4'(k);
      end
    end
    return d;
  endfunction

  function automatic logic [MV_W-1:0] dec_rem(input logic [MV_W-1:0] v, input int w);
    logic [MV_W-1:0] r;
    r = v;
    for (int k = 1; k < 10; k++) begin
      if (int'(v) >= k * w) begin
        r = MV_W'(int'(v) - k * w);
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* sv/amar_front.sv */
// ----------------------------------------------------------------------------
// amar_front
// keeps the last sample, drops unchanged ones, scales changed ones to millivolts
// ----------------------------------------------------------------------------
`default_nettype none

module amar_front import amar_pkg::*; #(
  parameter int SAMPLE_BITS = 10
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [SAMPLE_BITS-1:0] in_sample,
  output logic                        push,
  input  wire logic                   push_ready,
  output logic [MV_W-1:0]             push_mv
);

  logic [SAMPLE_BITS-1:0] previous;
  logic                   changed;
  logic                   accept;

  assign in_ready = push_ready;
  assign accept   = in_valid && in_ready;
  assign changed  = (in_sample != previous);
  assign push     = accept && changed;
  // times five as shift and add
  assign push_mv  = MV_W'(in_sample) + (MV_W'(in_sample) << 2);

  always_ff @(posedge clk) begin
    if (rst) begin
      previous <= '0;
    end else if (push) begin
      previous <= in_sample;
    end
  end

endmodule

`default_nettype wire

/* sv/amar_queue.sv */
// ----------------------------------------------------------------------------
// amar_queue
// short fifo of millivolt values between the front and the byte sequencer
// ----------------------------------------------------------------------------
`default_nettype none

module amar_queue import amar_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  output logic                 push_ready,
  input  wire logic [MV_W-1:0] push_mv,
  output logic                 pop_valid,
  input  wire logic            pop,
  output logic [MV_W-1:0]      pop_mv
);

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  logic [MV_W-1:0]  entries [Q_DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNT_W'(Q_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_mv     = entries[rptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wptr] <= push_mv;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PTR_W'(Q_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PTR_W'(Q_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

/* sv/amar_back.sv */
// ----------------------------------------------------------------------------
// amar_back
// byte sequencer: one decimal digit or fixed byte per cycle unless the output stalls, into the output register
// ----------------------------------------------------------------------------
`default_nettype none

module amar_back import amar_pkg::*; #(
  parameter int BACKSPACE_COUNT = 5
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            pop_valid,
  output logic                 pop,
  input  wire logic [MV_W-1:0] pop_mv,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [7:0]           out_char,
  output logic                 out_last
);

  localparam int LAST_POS = DIGIT_BYTES - 1 + BACKSPACE_COUNT;
  localparam int PW       = $clog2(LAST_POS + 1);

  logic            busy;
  logic [PW-1:0]   pos;
  logic [MV_W-1:0] rem;
  logic            load_out;
  logic            finishing;
  logic [7:0]      byte_char;
  logic [MV_W-1:0] rem_next;

  assign load_out  = !out_valid || out_ready;
  assign finishing = busy && load_out && (pos == PW'(LAST_POS));
  assign pop       = pop_valid && (!busy || finishing);

  always_comb begin
    byte_char = ASCII_BACKSPACE;
    rem_next  = rem;
    if (pos == PW'(POS_THOUS)) begin
      byte_char = ASCII_ZERO + {4'b0, dec_digit(rem, 1000)};
      rem_next  = dec_rem(rem, 1000);
    end else if (pos == PW'(POS_POINT)) begin
      byte_char = ASCII_POINT;
    end else if (pos == PW'(POS_HUND)) begin
      byte_char = ASCII_ZERO + {4'b0, dec_digit(rem, 100)};
      rem_next  = dec_rem(rem, 100);
    end else if (pos == PW'(POS_TENS)) begin
      byte_char = ASCII_ZERO + {4'b0, dec_digit(rem, 10)};
      rem_next  = dec_rem(rem, 10);
    end else if (pos == PW'(POS_UNITS)) begin
      byte_char = ASCII_ZERO + {4'b0, rem[3:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      pos       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= busy;
        if (busy) begin
          out_char <= byte_char;
          out_last <= (pos == PW'(LAST_POS));
        end
      end
      if (pop) begin
        busy <= 1'b1;
        rem  <= pop_mv;
        pos  <= '0;
      end else if (busy && load_out) begin
        busy <= !finishing;
        rem  <= rem_next;
        pos  <= finishing ? '0 : pos + 1'b1;
      end
    end
  end

  a_last_byte: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_last) |-> ((BACKSPACE_COUNT == 0) || (out_char == ASCII_BACKSPACE)))
    else $error("last byte of a report is not a backspace");

  a_idle_pos: assert property (@(posedge clk) disable iff (rst)
    !busy |-> (pos == '0))
    else $error("sequencer idle with nonzero position");

  a_units_range: assert property (@(posedge clk) disable iff (rst)
    (busy && (pos == PW'(POS_UNITS))) |-> (rem < MV_W'(10)))
    else $error("remainder out of range at units digit");

endmodule

`default_nettype wire

/* sv/adc_millivolt_ascii_reporter_core.sv */
// the first byte of a report passes the queue, the sequencer registers and the output register
// a changed sample gives a report of 5 + BACKSPACE_COUNT bytes (10 by default), paced by
//   the byte sequencer emitting one byte per cycle while not stalled; unchanged samples give none
// a two-entry queue lets new samples be taken while a report is still going out
// reset: synchronous, clears the stored sample to 0, the queue and the valid bit of the output register
// ----------------------------------------------------------------------------
// adc_millivolt_ascii_reporter_core
// reports changed converter samples as ascii millivolt strings with backspaces
// ----------------------------------------------------------------------------
`default_nettype none

module adc_millivolt_ascii_reporter_core import amar_pkg::*; #(
  parameter int SAMPLE_BITS     = 10,
  parameter int BACKSPACE_COUNT = 5
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // sample [9:0], zero pad
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // out_char [7:0]
  output logic             m_tlast
);

  logic            push;
  logic            push_ready;
  logic [MV_W-1:0] push_mv;
  logic            pop_valid;
  logic            pop;
  logic [MV_W-1:0] pop_mv;

  amar_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_sample (s_tdata[SAMPLE_BITS-1:0]),
    .push      (push),
    .push_ready(push_ready),
    .push_mv   (push_mv)
  );

  amar_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_ready(push_ready),
    .push_mv   (push_mv),
    .pop_valid (pop_valid),
    .pop       (pop),
    .pop_mv    (pop_mv)
  );

  amar_back #(
    .BACKSPACE_COUNT(BACKSPACE_COUNT)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .pop_valid(pop_valid),
    .pop      (pop),
    .pop_mv   (pop_mv),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_char (m_tdata),
    .out_last (m_tlast)
  );

endmodule

`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the millivolt ascii reporter: converter samples are
// streamed in with random gaps, each accepted request is run through a local
// model of the reporter, and every output byte is compared in order against
// the predicted ascii report under random output stalls
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import amar_pkg::*;

  localparam int SAMPLE_W   = 10;
  localparam int BS_COUNT   = 5;
  localparam int MAX_SHOWN  = 40;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } report_byte_t;

  typedef struct {
    bit                  drain;
    logic [SAMPLE_W-1:0] value;
  } sample_req_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata  = '0;  // sample [9:0], zero pad
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;        // out_char [7:0]
  logic        m_tlast;

  sample_req_t         pending_samples[$];
  report_byte_t        expected_bytes[$];
  logic [SAMPLE_W-1:0] shown_sample;
  int                  n_errors  = 0;
  int                  n_samples = 0;
  int                  n_changed = 0;
  int                  n_bytes   = 0;
  int                  n_reports = 0;
  bit                  gaps_on;

  adc_millivolt_ascii_reporter_core #(
    .SAMPLE_BITS     (SAMPLE_W),
    .BACKSPACE_COUNT (BS_COUNT)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #5 clk = ~clk;

  // no gaps or stalls while the middle block of samples goes through
  assign gaps_on = !(n_samples >= 50 && n_samples < 80);

  task automatic report_mismatch(input string msg);
    if (n_errors < MAX_SHOWN) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
    n_errors++;
  endtask

  task automatic predict_report(input logic [SAMPLE_W-1:0] smp);
    int mv;
    if (smp == shown_sample) begin
      return;
    end
    shown_sample = smp;
    n_changed++;
    mv = int'(smp) * MV_PER_COUNT;
    expected_bytes.push_back('{ASCII_ZERO + 8'((mv / 1000) % 10), 1'b0});
    expected_bytes.push_back('{ASCII_POINT, 1'b0});
    expected_bytes.push_back('{ASCII_ZERO + 8'((mv / 100) % 10), 1'b0});
    expected_bytes.push_back('{ASCII_ZERO + 8'((mv / 10) % 10), 1'b0});
    expected_bytes.push_back('{ASCII_ZERO + 8'(mv % 10), 1'(BS_COUNT == 0)});
    for (int i = 0; i < BS_COUNT; i++) begin
      expected_bytes.push_back('{ASCII_BACKSPACE, 1'(i == BS_COUNT - 1)});
    end
  endtask

  // sample driver
  always @(posedge clk) begin
    sample_req_t nxt;
    if (rst) begin
      s_tvalid     <= 1'b0;
      s_tdata      <= '0;
      shown_sample = '0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_report(s_tdata[SAMPLE_W-1:0]);
        n_samples++;
      end
      if (!s_tvalid || s_tready) begin
        if (pending_samples.size() > 0 && pending_samples[0].drain &&
            expected_bytes.size() == 0) begin
          void'(pending_samples.pop_front());
        end
        if (pending_samples.size() > 0 && !pending_samples[0].drain &&
            !(gaps_on && $urandom_range(99) < 15)) begin
          nxt = pending_samples.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {{(16 - SAMPLE_W){1'b0}}, nxt.value};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // report byte monitor
  always @(posedge clk) begin
    report_byte_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        n_bytes++;
        if (expected_bytes.size() == 0) begin
          report_mismatch($sformatf("unexpected byte %0d last %0d", m_tdata, m_tlast));
        end else begin
          want = expected_bytes.pop_front();
          if (m_tdata !== want.ch) begin
            report_mismatch($sformatf("byte %0d, want %0d", m_tdata, want.ch));
          end
          if (m_tlast !== want.last) begin
            report_mismatch($sformatf("last %0d, want %0d", m_tlast, want.last));
          end
        end
        if (m_tlast === 1'b1) begin
          n_reports++;
        end
      end
      m_tready <= !(gaps_on && $urandom_range(99) < 15);
    end
  end

  task automatic queue_sample(input logic [SAMPLE_W-1:0] v);
    pending_samples.push_back('{1'b0, v});
  endtask

  task automatic queue_drain();
    pending_samples.push_back('{1'b1, '0});
  endtask

  initial begin
    logic [SAMPLE_W-1:0] prev;
    logic [SAMPLE_W-1:0] v;
    int                  pick;

    // zero after reset matches the stored value, then extremes and digit edges
    queue_sample(10'd0);
    queue_sample(10'd0);
    queue_sample(10'd1023);
    queue_sample(10'd1023);
    queue_sample(10'd1);
    queue_sample(10'd0);
    queue_sample(10'd200);
    queue_sample(10'd199);
    queue_sample(10'd2);
    queue_sample(10'd20);
    queue_sample(10'd512);
    queue_sample(10'd511);
    queue_sample(10'h155);
    queue_sample(10'h2aa);
    queue_sample(10'h2aa);
    queue_sample(10'd1000);
    queue_sample(10'd999);
    queue_drain();
    prev = 10'd999;
    for (int i = 0; i < 93; i++) begin
      pick = $urandom_range(99);
      if (pick < 20) begin
        v = prev;
      end else if (pick < 30) begin
        v = 10'(1 << $urandom_range(SAMPLE_W - 1));
        if ($urandom_range(1)) begin
          v = ~v;
        end
      end else if (pick < 36) begin
        v = $urandom_range(1) ? 10'd1023 : 10'd0;
      end else if (pick < 45) begin
        v = prev + 10'(($urandom_range(1) ? 1 : -1));
      end else begin
        v = 10'($urandom_range(1023));
      end
      queue_sample(v);
      prev = v;
      if (i == 55) begin
        queue_drain();
      end
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (pending_samples.size() > 0 || s_tvalid || expected_bytes.size() > 0) begin
      @(posedge clk);
    end
    repeat (30) @(posedge clk);

    $display("%0d samples sent, %0d changed values reported in %0d reports",
             n_samples, n_changed, n_reports);
    $display("%0d ascii bytes checked under random input gaps and output stalls", n_bytes);
    if (n_errors == 0) begin
      $display("adc_millivolt_ascii_reporter_core verification clean");
    end else begin
      $display("adc_millivolt_ascii_reporter_core verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d bytes still expected", expected_bytes.size());
    $display("adc_millivolt_ascii_reporter_core verification failed");
    $finish;
  end

endmodule

`default_nettype wire
